### design/nsm_pkg.sv
// ----------------------------------------------------------------------------
// nsm_pkg: shared types and constants of the nfa symbol matcher
// Default sizes, opcodes, status codes, register indexes and stream widths.
// ----------------------------------------------------------------------------
package nsm_pkg;

    // default automaton size
    localparam int NSM_NUM_STATES  = 16;
    localparam int NSM_NUM_SYMBOLS = 32;
    localparam int NSM_MAX_STATES  = 64;

    // field widths of a request and a result
    localparam int OPCODE_W = 3;
    localparam int SOURCE_W = 4;
    localparam int SYMBOL_W = 5;
    localparam int TARGET_W = 16;
    localparam int ACTIVE_W = 16;
    localparam int STATUS_W = 2;

    // stream data widths, padded to whole bytes
    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 24;

    // configuration port
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 32;

    localparam logic [CFG_INDEX_W-1:0] REG_START_STATE   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_ACCEPT_MASK   = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_ALPHABET_MASK = 2'd2;

    // request opcodes
    typedef enum logic [OPCODE_W-1:0] {
        OP_LOAD_SYM = 3'd0,
        OP_LOAD_EPS = 3'd1,
        OP_START    = 3'd2,
        OP_FEED     = 3'd3,
        OP_FINISH   = 3'd4
    } op_t;

    // sticky status codes
    localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
    localparam logic [STATUS_W-1:0] ST_BAD_SYMBOL = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY      = 2'd2;

endpackage

### design/nsm_closure.sv
// ----------------------------------------------------------------------------
// nsm_closure: epsilon table and iterative closure engine
// Holds one epsilon row per state and expands a seed set one pending state
// per cycle until no new state appears.
// ----------------------------------------------------------------------------
module nsm_closure #(
    parameter int NUM_STATES = 16,
    parameter int IDX_W      = $clog2(NUM_STATES)
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  eps_we,
    input  logic [IDX_W-1:0]      eps_idx,
    input  logic [NUM_STATES-1:0] eps_row,
    input  logic                  start,
    input  logic [NUM_STATES-1:0] seed,
    output logic                  done,
    output logic [NUM_STATES-1:0] result
);

    logic [NUM_STATES-1:0] eps_reg [NUM_STATES];
    logic [NUM_STATES-1:0] set_reg;
    logic [NUM_STATES-1:0] set_next;
    logic [NUM_STATES-1:0] pend_reg;
    logic [NUM_STATES-1:0] pend_next;
    logic                  busy_reg;
    logic                  busy_next;
    logic [NUM_STATES-1:0] low_bit;
    logic [NUM_STATES-1:0] row_sel;

    // epsilon rows, cleared at reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_STATES; i++)
            begin
                eps_reg[i] <= '0;
            end
        end
        else if (eps_we)
        begin
            eps_reg[eps_idx] <= eps_row;
        end
    end

    // pick the lowest pending state and fetch its row
    always_comb
    begin
        low_bit = pend_reg & (~pend_reg + 1'b1);
        row_sel = '0;
        for (int j = 0; j < NUM_STATES; j++)
        begin
            if (low_bit[j])
            begin
                row_sel = row_sel | eps_reg[j];
            end
        end
    end

    assign done   = busy_reg && (pend_reg == '0);
    assign result = set_reg;

    // one expansion step per cycle
    always_comb
    begin
        set_next  = set_reg;
        pend_next = pend_reg;
        busy_next = busy_reg;
        if (start)
        begin
            set_next  = seed;
            pend_next = seed;
            busy_next = 1'b1;
        end
        else if (done)
        begin
            busy_next = 1'b0;
        end
        else if (busy_reg)
        begin
            set_next  = set_reg | row_sel;
            pend_next = (pend_reg & ~low_bit) | (row_sel & ~set_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        set_reg  <= set_next;
        pend_reg <= pend_next;
    end

endmodule

### design/nfa_symbol_matcher.sv
// ----------------------------------------------------------------------------
// nfa_symbol_matcher: indexed nfa simulator with epsilon closure
// Loads transition rows, runs strings symbol by symbol, reports acceptance.
// ----------------------------------------------------------------------------
// Usage
//   Requests arrive on the s_axis channel, one result per request leaves on
//   the m_axis channel. Registers are written through cfg_we / cfg_index /
//   cfg_data while no request is in flight.
//   Flow: a load, finish, unused opcode, out of range start, feed with a
//   symbol outside the alphabet or feed under a reject status goes from
//   dispatch straight to the output register. A good start runs the closure
//   engine, which expands one pending state per cycle and then reports done.
//   A feed first scans the rows (one symbol table read per state through the
//   single memory read port), then runs the closure and then loads the output
//   register. One request is in work at a time; s_axis_tready is high only
//   while the sequencer is idle between requests.
//   Reset: after rst_n rises the symbol table is cleared one entry per cycle,
//   all NUM_STATES * NUM_SYMBOLS entries (512 at the default size), with
//   s_axis_tready low. Registers, epsilon rows and status clear at once.
//   Stall: a finished result sits in the output register until taken; the
//   next request is accepted meanwhile, and its result waits until the
//   output register is free.
// ----------------------------------------------------------------------------
module nfa_symbol_matcher #(
    parameter int NUM_STATES  = nsm_pkg::NSM_NUM_STATES,
    parameter int NUM_SYMBOLS = nsm_pkg::NSM_NUM_SYMBOLS
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // config write port
    input  logic                             cfg_we,
    input  logic [nsm_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [nsm_pkg::CFG_DATA_W-1:0]   cfg_data,
    // request channel
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // opcode[2:0], source_state[6:3], symbol_index[11:7], target_mask[27:12]
    input  logic [nsm_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    // result channel
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // active_set[15:0], accepted[16], status[18:17]
    output logic [nsm_pkg::OUT_DATA_W-1:0]   m_axis_tdata
);

    import nsm_pkg::*;

    localparam int IDX_W = $clog2(NUM_STATES);
    localparam int CNT_W = $clog2(NUM_STATES + 1);
    localparam int DEPTH = NUM_STATES * NUM_SYMBOLS;
    localparam int ADR_W = $clog2(DEPTH);

    typedef enum logic [5:0] {
        S_CLEAR    = 6'b000001,
        S_IDLE     = 6'b000010,
        S_DISPATCH = 6'b000100,
        S_UNION    = 6'b001000,
        S_CLOSE    = 6'b010000,
        S_RESP     = 6'b100000
    } state_t;

    state_t                  state_reg, state_next;

    // configuration registers
    logic [SOURCE_W-1:0]     start_reg;
    logic [TARGET_W-1:0]     accept_reg;
    logic [CFG_DATA_W-1:0]   alpha_reg;

    // captured request
    logic [OPCODE_W-1:0]     op_reg, op_next;
    logic [SOURCE_W-1:0]     src_reg, src_next;
    logic [SYMBOL_W-1:0]     sym_reg, sym_next;
    logic [TARGET_W-1:0]     tgt_reg, tgt_next;

    // matcher state
    logic [NUM_STATES-1:0]   live_reg, live_next;
    logic [STATUS_W-1:0]     reject_reg, reject_next;

    // sequencer counters
    logic [ADR_W-1:0]        clr_reg, clr_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic                    take_reg, take_next;
    logic [NUM_STATES-1:0]   union_reg, union_next;

    // output register
    logic                    out_valid_reg, out_valid_next;
    logic [OUT_DATA_W-1:0]   out_data_reg, out_data_next;

    // symbol table memory
    logic [NUM_STATES-1:0]   sym_mem [DEPTH];
    logic                    mem_we;
    logic [ADR_W-1:0]        mem_waddr;
    logic [NUM_STATES-1:0]   mem_wdata;
    logic                    rd_en;
    logic [ADR_W-1:0]        rd_addr;
    logic [NUM_STATES-1:0]   rd_q;

    // closure engine hookup
    logic                    eps_we;
    logic                    clo_start;
    logic [NUM_STATES-1:0]   clo_seed;
    logic                    clo_done;
    logic [NUM_STATES-1:0]   clo_result;

    // decoded request fields
    logic [7:0]              src_w;
    logic [7:0]              start_w;
    logic [IDX_W-1:0]        src_idx;
    logic [IDX_W-1:0]        cnt_idx;
    logic                    src_ok;
    logic                    sym_ok;
    logic                    in_alpha;
    logic                    start_ok;
    logic                    cnt_last;
    logic [NSM_MAX_STATES-1:0] tgt_wide;
    logic [NSM_MAX_STATES-1:0] acc_wide;
    logic [NSM_MAX_STATES-1:0] live_wide;
    logic [NUM_STATES-1:0]   tgt_n;
    logic [NUM_STATES-1:0]   acc_n;
    logic [NUM_STATES-1:0]   start_set;
    logic                    accepted;

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg  <= '0;
            accept_reg <= '0;
            alpha_reg  <= '0;
        end
        else if (cfg_we)
        begin
            if (cfg_index == REG_START_STATE)
            begin
                start_reg <= cfg_data[SOURCE_W-1:0];
            end
            if (cfg_index == REG_ACCEPT_MASK)
            begin
                accept_reg <= cfg_data[TARGET_W-1:0];
            end
            if (cfg_index == REG_ALPHABET_MASK)
            begin
                alpha_reg <= cfg_data;
            end
        end
    end

    // field decode and resizing to the state count
    always_comb
    begin
        src_w     = {4'b0, src_reg};
        start_w   = {4'b0, start_reg};
        src_idx   = src_w[IDX_W-1:0];
        cnt_idx   = cnt_reg[IDX_W-1:0];
        src_ok    = int'(src_reg) < NUM_STATES;
        sym_ok    = int'(sym_reg) < NUM_SYMBOLS;
        in_alpha  = sym_ok && alpha_reg[sym_reg];
        start_ok  = int'(start_reg) < NUM_STATES;
        cnt_last  = (cnt_reg == CNT_W'(NUM_STATES));
        tgt_wide  = '0;
        tgt_wide[TARGET_W-1:0] = tgt_reg;
        acc_wide  = '0;
        acc_wide[TARGET_W-1:0] = accept_reg;
        tgt_n     = tgt_wide[NUM_STATES-1:0];
        acc_n     = acc_wide[NUM_STATES-1:0];
        live_wide = '0;
        live_wide[NUM_STATES-1:0] = live_reg;
        start_set = '0;
        start_set[start_w[IDX_W-1:0]] = 1'b1;
        accepted  = (op_reg == OP_FINISH) && (reject_reg == ST_OK) &&
                    ((live_reg & acc_n) != '0);
    end

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        src_next       = src_reg;
        sym_next       = sym_reg;
        tgt_next       = tgt_reg;
        live_next      = live_reg;
        reject_next    = reject_reg;
        clr_next       = clr_reg;
        cnt_next       = cnt_reg;
        take_next      = 1'b0;
        union_next     = union_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        out_data_next  = out_data_reg;
        mem_we         = 1'b0;
        mem_waddr      = ADR_W'(int'(src_reg) * NUM_SYMBOLS + int'(sym_reg));
        mem_wdata      = tgt_n;
        rd_en          = 1'b0;
        rd_addr        = ADR_W'(int'(cnt_idx) * NUM_SYMBOLS + int'(sym_reg));
        eps_we         = 1'b0;
        clo_start      = 1'b0;
        clo_seed       = start_set;

        unique case (state_reg)
            // sweep zeros through the symbol table
            S_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                mem_wdata = '0;
                if (clr_reg == ADR_W'(DEPTH - 1))
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    clr_next = clr_reg + 1'b1;
                end
            end
            // take one request
            S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    op_next    = s_axis_tdata[2:0];
                    src_next   = s_axis_tdata[6:3];
                    sym_next   = s_axis_tdata[11:7];
                    tgt_next   = s_axis_tdata[27:12];
                    state_next = S_DISPATCH;
                end
            end
            // decode the opcode
            S_DISPATCH:
            begin
                state_next = S_RESP;
                unique case (op_reg)
                    OP_LOAD_SYM:
                    begin
                        mem_we = src_ok && sym_ok;
                    end
                    OP_LOAD_EPS:
                    begin
                        eps_we = src_ok;
                    end
                    OP_START:
                    begin
                        if (start_ok)
                        begin
                            reject_next = ST_OK;
                            clo_start   = 1'b1;
                            state_next  = S_CLOSE;
                        end
                        else
                        begin
                            live_next   = '0;
                            reject_next = ST_EMPTY;
                        end
                    end
                    OP_FEED:
                    begin
                        if (reject_reg == ST_OK)
                        begin
                            if (!in_alpha)
                            begin
                                reject_next = ST_BAD_SYMBOL;
                            end
                            else
                            begin
                                cnt_next   = '0;
                                union_next = '0;
                                state_next = S_UNION;
                            end
                        end
                    end
                    default:
                    begin
                        state_next = S_RESP;
                    end
                endcase
            end
            // or together the rows of the live states, one read per cycle
            S_UNION:
            begin
                rd_en      = !cnt_last;
                take_next  = cnt_last ? 1'b0 : live_reg[cnt_idx];
                union_next = union_reg | (take_reg ? rd_q : '0);
                cnt_next   = cnt_reg + 1'b1;
                if (cnt_last)
                begin
                    clo_start  = 1'b1;
                    clo_seed   = union_next;
                    state_next = S_CLOSE;
                end
            end
            // wait for the closure; commit it, or flag an empty feed result
            S_CLOSE:
            begin
                if (clo_done)
                begin
                    state_next = S_RESP;
                    if (op_reg != OP_START && clo_result == '0)
                    begin
                        reject_next = ST_EMPTY;
                    end
                    else
                    begin
                        live_next = clo_result;
                    end
                end
            end
            // hand the result to the output register
            S_RESP:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = {5'b0, reject_reg, accepted,
                                      live_wide[ACTIVE_W-1:0]};
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            live_reg      <= '0;
            reject_reg    <= ST_OK;
            clr_reg       <= '0;
            cnt_reg       <= '0;
            take_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            live_reg      <= live_next;
            reject_reg    <= reject_next;
            clr_reg       <= clr_next;
            cnt_reg       <= cnt_next;
            take_reg      <= take_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        src_reg      <= src_next;
        sym_reg      <= sym_next;
        tgt_reg      <= tgt_next;
        union_reg    <= union_next;
        out_data_reg <= out_data_next;
    end

    // symbol table: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            sym_mem[mem_waddr] <= mem_wdata;
        end
        if (rd_en)
        begin
            rd_q <= sym_mem[rd_addr];
        end
    end

    nsm_closure #(
        .NUM_STATES (NUM_STATES),
        .IDX_W      (IDX_W)
    ) u_closure (
        .clk     (clk),
        .rst_n   (rst_n),
        .eps_we  (eps_we),
        .eps_idx (src_idx),
        .eps_row (tgt_n),
        .start   (clo_start),
        .seed    (clo_seed),
        .done    (clo_done),
        .result  (clo_result)
    );

`ifndef SYNTHESIS
    // no request is taken during the clearing pass
    a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLEAR) |-> !s_axis_tready)
        else $error("request accepted while symbol table is clearing");

    // an accepted request is decoded next cycle
    a_accept_to_dispatch: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> (state_reg == S_DISPATCH))
        else $error("accepted request not dispatched");

    // closure completes only while the sequencer waits for it
    a_done_in_close: assert property (@(posedge clk) disable iff (!rst_n)
        clo_done |-> (state_reg == S_CLOSE))
        else $error("closure finished outside the close step");

    // acceptance is never reported with a reject status
    a_accept_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tdata[16]) |-> (m_axis_tdata[18:17] == ST_OK))
        else $error("accepted flag set with nonzero status");
`endif

endmodule
